// ----- design/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: shared package
// Field widths, command and status codes, configuration register indexes
// and the transaction records passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Completion status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUS_BUSY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUS_ERROR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ACK     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_TICKS = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] FAST_TICKS_RST = 8'd9;
  localparam logic [BYTE_W-1:0] SLOW_TICKS_RST = 8'd24;

  // One tick of input
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] device_addr;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] read_count;
    logic              sda_in;
  } req_t;

  // One tick of result
  typedef struct packed {
    logic                scl_out;
    logic                sda_out;
    logic [BYTE_W-1:0]   read_data;
    logic                read_valid;
    logic                read_last;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ----- design/i2cm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: request channel
// Valid/ready channel carrying one bus tick: command fields and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
  import i2cm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] device_addr;
  logic [BYTE_W-1:0] reg_addr;
  logic [BYTE_W-1:0] write_data;
  logic [BYTE_W-1:0] read_count;
  logic              sda_in;

  modport source (
    output valid, cmd, device_addr, reg_addr, write_data, read_count, sda_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, device_addr, reg_addr, write_data, read_count, sda_in,
    output ready
  );

endinterface

// ----- design/i2cm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: result channel
// Valid/ready channel carrying line drives, received data and status per tick.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
  import i2cm_pkg::*;

  logic                valid;
  logic                ready;
  logic                scl_out;
  logic                sda_out;
  logic [BYTE_W-1:0]   read_data;
  logic                read_valid;
  logic                read_last;
  logic                busy_res;
  logic                done_res;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, scl_out, sda_out, read_data, read_valid, read_last,
           busy_res, done_res, status,
    input  ready
  );

  modport sink (
    input  valid, scl_out, sda_out, read_data, read_valid, read_last,
           busy_res, done_res, status,
    output ready
  );

endinterface

// ----- design/i2cm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: configuration registers
// Holds the mode bit and both phase lengths; presents the active phase length.
// ----------------------------------------------------------------------------
module i2cm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cm_pkg::BYTE_W-1:0]      cfg_wdata,
  output logic [i2cm_pkg::BYTE_W-1:0]      phase_len
);
  import i2cm_pkg::*;

  logic              fast_mode;
  logic [BYTE_W-1:0] fast_ticks;
  logic [BYTE_W-1:0] slow_ticks;
  logic [BYTE_W-1:0] sel_ticks;

  // Write registers by index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_mode  <= 1'b0;
      fast_ticks <= FAST_TICKS_RST;
      slow_ticks <= SLOW_TICKS_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FAST_MODE:  fast_mode  <= cfg_wdata[0];
        CFG_FAST_TICKS: fast_ticks <= cfg_wdata;
        CFG_SLOW_TICKS: slow_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Select the phase length; a zero length counts as one tick
  always_comb begin
    sel_ticks = fast_mode ? fast_ticks : slow_ticks;
    phase_len = (sel_ticks == '0) ? BYTE_W'(1) : sel_ticks;
  end

endmodule

// ----- design/i2cm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: bus sequencer
// Phase state machine; computes the result of the current tick and advances
// its state when the tick is accepted.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  i2cm_pkg::req_t               req,
  input  logic [i2cm_pkg::BYTE_W-1:0]  phase_len,
  output i2cm_pkg::res_t               res
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3,
    PH_TX_LOW, PH_TX_DATA, PH_TX_HIGH,
    PH_AK_LOW, PH_AK_REL, PH_AK_HIGH, PH_AK_END,
    PH_RX_LOW, PH_RX_HIGH,
    PH_MA_LOW, PH_MA_DRIVE, PH_MA_HIGH, PH_MA_END,
    PH_SP1, PH_SP2, PH_SP3, PH_SP4
  } phase_t;

  // Byte stage within a transaction
  typedef enum logic [1:0] {
    SG_DEVICE, SG_REGISTER, SG_DATA, SG_RECEIVE
  } stage_t;

  // Stored state
  phase_t            phase;
  logic [BYTE_W-1:0] timer;
  logic [3:0]        bit_index;
  logic [BYTE_W-1:0] shift_byte;
  logic [BYTE_W-1:0] bytes_left;
  logic [BYTE_W-1:0] saved_device;
  logic [BYTE_W-1:0] saved_register;
  logic [BYTE_W-1:0] saved_data;
  logic              is_read;
  stage_t            stage;
  logic              addr_nack;
  logic              scl_drv;
  logic              sda_drv;

  // State as seen this tick, after a possible command start
  phase_t            cur_phase;
  logic [BYTE_W-1:0] cur_timer;
  logic [3:0]        cur_bit;
  logic [BYTE_W-1:0] cur_shift;
  logic [BYTE_W-1:0] cur_bytes;
  logic [BYTE_W-1:0] cur_device;
  logic [BYTE_W-1:0] cur_register;
  logic [BYTE_W-1:0] cur_data;
  logic              cur_read;
  stage_t            cur_stage;
  logic              cur_nack;
  logic              cur_scl;
  logic              cur_sda;

  // Next state
  phase_t            phase_next;
  logic [BYTE_W-1:0] timer_next;
  logic [3:0]        bit_index_next;
  logic [BYTE_W-1:0] shift_byte_next;
  logic [BYTE_W-1:0] bytes_left_next;
  stage_t            stage_next;
  logic              addr_nack_next;
  logic              scl_drv_next;
  logic              sda_drv_next;

  logic              start;
  logic              zero_cnt;
  logic [BYTE_W-1:0] timer_inc;
  logic [3:0]        bit_inc;
  logic              do_enter;
  phase_t            target;

  // Decode command and pick the state that this tick works on
  always_comb begin
    start    = (phase == PH_IDLE) && ((req.cmd == CMD_WRITE) || (req.cmd == CMD_READ));
    zero_cnt = start && (req.cmd == CMD_READ) && (req.read_count == '0);
    if (start && !zero_cnt) begin
      cur_phase    = PH_ST1;
      cur_timer    = '0;
      cur_bit      = '0;
      cur_shift    = '0;
      cur_bytes    = req.read_count;
      cur_device   = req.device_addr;
      cur_register = req.reg_addr;
      cur_data     = req.write_data;
      cur_read     = (req.cmd == CMD_READ);
      cur_stage    = SG_DEVICE;
      cur_nack     = 1'b0;
      cur_scl      = 1'b1;
      cur_sda      = 1'b1;
    end else begin
      cur_phase    = phase;
      cur_timer    = timer;
      cur_bit      = bit_index;
      cur_shift    = shift_byte;
      cur_bytes    = bytes_left;
      cur_device   = saved_device;
      cur_register = saved_register;
      cur_data     = saved_data;
      cur_read     = is_read;
      cur_stage    = stage;
      cur_nack     = addr_nack;
      cur_scl      = scl_drv;
      cur_sda      = sda_drv;
    end
  end

  // Tick result and phase transitions
  always_comb begin
    phase_next      = cur_phase;
    timer_next      = cur_timer;
    bit_index_next  = cur_bit;
    shift_byte_next = cur_shift;
    bytes_left_next = cur_bytes;
    stage_next      = cur_stage;
    addr_nack_next  = cur_nack;
    scl_drv_next    = cur_scl;
    sda_drv_next    = cur_sda;
    do_enter        = 1'b0;
    target          = PH_IDLE;
    timer_inc       = cur_timer + BYTE_W'(1);
    bit_inc         = cur_bit + 4'd1;

    res         = '0;
    res.scl_out = 1'b1;
    res.sda_out = 1'b1;

    if (zero_cnt) begin
      // Reject an empty read at once, no bus activity
      res.done_res = 1'b1;
      res.status   = ST_ZERO_COUNT;
    end else if (cur_phase != PH_IDLE) begin
      res.scl_out  = cur_scl;
      res.sda_out  = cur_sda;
      res.busy_res = 1'b1;
      if (timer_inc >= phase_len) begin
        timer_next = '0;
        case (cur_phase)
          PH_ST1: begin
            if ((cur_stage == SG_DEVICE) && !req.sda_in) begin
              phase_next   = PH_IDLE;
              scl_drv_next = 1'b1;
              sda_drv_next = 1'b1;
              res.done_res = 1'b1;
              res.status   = ST_BUS_BUSY;
            end else begin
              do_enter = 1'b1;
              target   = PH_ST2;
            end
          end
          PH_ST2: begin
            if ((cur_stage == SG_DEVICE) && req.sda_in) begin
              phase_next   = PH_IDLE;
              scl_drv_next = 1'b1;
              sda_drv_next = 1'b1;
              res.done_res = 1'b1;
              res.status   = ST_BUS_ERROR;
            end else begin
              do_enter = 1'b1;
              target   = PH_ST3;
            end
          end
          PH_ST3: begin
            shift_byte_next = (cur_stage == SG_DEVICE) ? cur_device
                                                       : cur_device + BYTE_W'(1);
            bit_index_next  = '0;
            do_enter        = 1'b1;
            target          = PH_TX_LOW;
          end
          PH_TX_LOW: begin
            do_enter = 1'b1;
            target   = PH_TX_DATA;
          end
          PH_TX_DATA: begin
            do_enter = 1'b1;
            target   = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            shift_byte_next = {cur_shift[BYTE_W-2:0], 1'b0};
            bit_index_next  = bit_inc;
            do_enter        = 1'b1;
            target          = bit_inc[3] ? PH_AK_LOW : PH_TX_LOW;
          end
          PH_AK_LOW: begin
            do_enter = 1'b1;
            target   = PH_AK_REL;
          end
          PH_AK_REL: begin
            do_enter = 1'b1;
            target   = PH_AK_HIGH;
          end
          PH_AK_HIGH: begin
            // Only the device address acknowledge is checked
            if ((cur_stage == SG_DEVICE) && req.sda_in) begin
              addr_nack_next = 1'b1;
            end
            do_enter = 1'b1;
            target   = PH_AK_END;
          end
          PH_AK_END: begin
            do_enter = 1'b1;
            case (cur_stage)
              SG_DEVICE: begin
                if (cur_nack) begin
                  target = PH_SP1;
                end else begin
                  stage_next      = SG_REGISTER;
                  shift_byte_next = cur_register;
                  bit_index_next  = '0;
                  target          = PH_TX_LOW;
                end
              end
              SG_REGISTER: begin
                if (cur_read) begin
                  stage_next = SG_RECEIVE;
                  target     = PH_ST1;
                end else begin
                  stage_next      = SG_DATA;
                  shift_byte_next = cur_data;
                  bit_index_next  = '0;
                  target          = PH_TX_LOW;
                end
              end
              SG_DATA: begin
                target = PH_SP1;
              end
              default: begin
                bit_index_next  = '0;
                shift_byte_next = '0;
                target          = PH_RX_LOW;
              end
            endcase
          end
          PH_RX_LOW: begin
            do_enter = 1'b1;
            target   = PH_RX_HIGH;
          end
          PH_RX_HIGH: begin
            shift_byte_next = {cur_shift[BYTE_W-2:0], req.sda_in};
            bit_index_next  = bit_inc;
            do_enter        = 1'b1;
            if (bit_inc[3]) begin
              res.read_data  = {cur_shift[BYTE_W-2:0], req.sda_in};
              res.read_valid = 1'b1;
              res.read_last  = (cur_bytes <= BYTE_W'(1));
              if (cur_bytes != '0) begin
                bytes_left_next = cur_bytes - BYTE_W'(1);
              end
              target = PH_MA_LOW;
            end else begin
              target = PH_RX_LOW;
            end
          end
          PH_MA_LOW: begin
            do_enter = 1'b1;
            target   = PH_MA_DRIVE;
          end
          PH_MA_DRIVE: begin
            do_enter = 1'b1;
            target   = PH_MA_HIGH;
          end
          PH_MA_HIGH: begin
            do_enter = 1'b1;
            target   = PH_MA_END;
          end
          PH_MA_END: begin
            do_enter = 1'b1;
            if (cur_bytes != '0) begin
              bit_index_next  = '0;
              shift_byte_next = '0;
              target          = PH_RX_LOW;
            end else begin
              target = PH_SP1;
            end
          end
          PH_SP1: begin
            do_enter = 1'b1;
            target   = PH_SP2;
          end
          PH_SP2: begin
            do_enter = 1'b1;
            target   = PH_SP3;
          end
          PH_SP3: begin
            do_enter = 1'b1;
            target   = PH_SP4;
          end
          PH_SP4: begin
            phase_next   = PH_IDLE;
            scl_drv_next = 1'b1;
            sda_drv_next = 1'b1;
            res.done_res = 1'b1;
            res.status   = cur_nack ? ST_NO_ACK : ST_OK;
          end
          default: begin
            phase_next   = PH_IDLE;
            scl_drv_next = 1'b1;
            sda_drv_next = 1'b1;
            res.done_res = 1'b1;
            res.status   = ST_OK;
          end
        endcase
      end else begin
        timer_next = timer_inc;
      end
    end

    // Set line drives for the phase being entered
    if (do_enter) begin
      phase_next = target;
      case (target)
        PH_ST1: begin
          scl_drv_next = 1'b1;
          sda_drv_next = 1'b1;
        end
        PH_ST2, PH_ST3: begin
          scl_drv_next = 1'b1;
          sda_drv_next = 1'b0;
        end
        PH_TX_DATA:  sda_drv_next = shift_byte_next[BYTE_W-1];
        PH_AK_REL:   sda_drv_next = 1'b1;
        PH_RX_LOW: begin
          scl_drv_next = 1'b0;
          sda_drv_next = 1'b1;
        end
        PH_MA_DRIVE: sda_drv_next = (bytes_left_next == '0);
        PH_SP2:      sda_drv_next = 1'b0;
        PH_SP4:      sda_drv_next = 1'b1;
        PH_TX_HIGH, PH_AK_HIGH, PH_RX_HIGH, PH_MA_HIGH, PH_SP3: scl_drv_next = 1'b1;
        default:     scl_drv_next = 1'b0;
      endcase
    end
  end

  // Hold state; advance on an accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      timer          <= '0;
      bit_index      <= '0;
      shift_byte     <= '0;
      bytes_left     <= '0;
      saved_device   <= '0;
      saved_register <= '0;
      saved_data     <= '0;
      is_read        <= 1'b0;
      stage          <= SG_DEVICE;
      addr_nack      <= 1'b0;
      scl_drv        <= 1'b1;
      sda_drv        <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      timer          <= timer_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      saved_device   <= cur_device;
      saved_register <= cur_register;
      saved_data     <= cur_data;
      is_read        <= cur_read;
      stage          <= stage_next;
      addr_nack      <= addr_nack_next;
      scl_drv        <= scl_drv_next;
      sda_drv        <= sda_drv_next;
    end
  end

endmodule

// ----- design/i2c_master_register_access_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: top level
// Open-drain I2C master running one register write or burst read per command.
//
// Usage:
//   req carries one bus tick per transfer: a command (none, write, read)
//   with its address, data and count fields, plus the sampled SDA level.
//   A command is taken only while no bus transaction is running.
//   rsp returns one result per tick: SCL/SDA drives (1 releases the line),
//   a received byte with its valid and last flags, busy, done and status.
//   The configuration port sets fast/slow mode and the two phase lengths;
//   write it only while the block is idle.
//   Each accepted tick's result is loaded into the output register. One
//   tick is accepted every cycle while rsp takes results, set by the
//   sequencer update between the state registers and the output register.
//   When rsp stalls, the result is held and req is not ready until the
//   result is taken; ticks are never dropped.
//   Reset is synchronous: the sequencer goes idle with both lines released,
//   the output register empties and the configuration returns to defaults.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cm_pkg::BYTE_W-1:0]      cfg_wdata,
  i2cm_req_if.sink                         req,
  i2cm_rsp_if.source                       rsp
);
  import i2cm_pkg::*;

  logic              step;
  logic [BYTE_W-1:0] phase_len;
  req_t              req_data;
  res_t              res_data;
  res_t              res_reg;
  logic              res_valid;

  // Accept a tick when the output register is free or being emptied
  assign req.ready = !res_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  // Gather the request payload
  always_comb begin
    req_data.cmd         = req.cmd;
    req_data.device_addr = req.device_addr;
    req_data.reg_addr    = req.reg_addr;
    req_data.write_data  = req.write_data;
    req_data.read_count  = req.read_count;
    req_data.sda_in      = req.sda_in;
  end

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .phase_len (phase_len)
  );

  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .req       (req_data),
    .phase_len (phase_len),
    .res       (res_data)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res_data;
    end
  end

  // Drive the result channel
  assign rsp.valid      = res_valid;
  assign rsp.scl_out    = res_reg.scl_out;
  assign rsp.sda_out    = res_reg.sda_out;
  assign rsp.read_data  = res_reg.read_data;
  assign rsp.read_valid = res_reg.read_valid;
  assign rsp.read_last  = res_reg.read_last;
  assign rsp.busy_res   = res_reg.busy_res;
  assign rsp.done_res   = res_reg.done_res;
  assign rsp.status     = res_reg.status;

endmodule
